// ===== hw/rtl/rrts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants for the round robin thread scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

    localparam int MAX_THREADS_DEF = 64;
    localparam int CNT_W           = 31;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_SPAWN = 2'd0,
        CMD_TERM  = 2'd1,
        CMD_YIELD = 2'd2,
        CMD_QUERY = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_NO_ID     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_SHUTDOWN  = 3'd4,
        ST_SLEEP     = 3'd5
    } status_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [5:0]  tid;
        logic [31:0] entry_addr;
        logic [7:0]  sleep_count;
    } req_t;

    typedef struct packed {
        status_t          status;
        logic [CNT_W-1:0] value;
        logic [5:0]       running_thread;
        logic [CNT_W-1:0] total_quanta;
    } rsp_t;

endpackage

// ===== hw/rtl/round_robin_thread_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler
// Round robin scheduler: spawn, terminate, yield and query per request.
// Spawn walks the live flags for a free id (free-id walk); terminate compacts
// the ready FIFO, one FIFO entry per cycle while compacting.
// One request at a time; the next is taken while a response waits to be taken.
// Reset is immediate: thread 0 live and running, no clearing pass.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler #(
    parameter int MAX_THREADS = rrts_pkg::MAX_THREADS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  rrts_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output rrts_pkg::rsp_t rsp
);

    logic           core_valid;
    logic           core_take;
    rrts_pkg::rsp_t core_rsp;
    logic           rsp_valid_reg, rsp_valid_next;
    rrts_pkg::rsp_t rsp_reg;

    rrts_core #(.MAX_THREADS(MAX_THREADS)) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (core_valid),
        .rsp_take  (core_take),
        .rsp       (core_rsp)
    );

    assign core_take = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (core_valid && core_take)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_valid && core_take)
        begin
            rsp_reg <= core_rsp;
        end
    end

endmodule

// ===== hw/rtl/rrts_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rrts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/rrts_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_core
// Command sequencer: live flags, ready FIFO ring and quantum count memory.
// ----------------------------------------------------------------------------
module rrts_core #(
    parameter int MAX_THREADS = rrts_pkg::MAX_THREADS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  rrts_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_take,
    output rrts_pkg::rsp_t rsp
);

    localparam int IW = $clog2(MAX_THREADS);
    localparam int CW = $clog2(MAX_THREADS + 1);
    localparam int QW = rrts_pkg::CNT_W;

    typedef enum logic [9:0] {
        S_IDLE      = 10'b0000000001,
        S_SEARCH    = 10'b0000000010,
        S_COMPACT   = 10'b0000000100,
        S_PUSH      = 10'b0000001000,
        S_HEAD_RD   = 10'b0000010000,
        S_HEAD_DATA = 10'b0000100000,
        S_Q_RD      = 10'b0001000000,
        S_Q_DATA    = 10'b0010000000,
        S_QRY_DATA  = 10'b0100000000,
        S_RESP      = 10'b1000000000
    } state_t;

    state_t                state_reg, state_next;
    logic [MAX_THREADS-1:0] live_reg, live_next;
    logic [IW-1:0]         head_reg, head_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [IW-1:0]         cur_reg, cur_next;
    logic [QW-1:0]         total_reg, total_next;
    logic                  q0_wr_reg, q0_wr_next;
    logic [IW-1:0]         idx_reg, idx_next;
    logic [IW-1:0]         tid_reg, tid_next;
    logic [IW-1:0]         nxt_reg, nxt_next;
    logic [CW-1:0]         rd_reg, rd_next;
    logic [CW-1:0]         w_reg, w_next;
    logic                  pend_reg, pend_next;
    logic [IW-1:0]         qra_reg, qra_next;
    rrts_pkg::status_t     status_reg, status_next;
    logic [QW-1:0]         value_reg, value_next;

    logic          f_we;
    logic [IW-1:0] f_waddr, f_wdata, f_raddr, f_rdata;
    logic          q_we;
    logic [IW-1:0] q_waddr, q_raddr;
    logic [QW-1:0] q_wdata, q_rdata, q_val;

    logic [IW-1:0] tid_idx;
    logic          tid_ok;
    logic          rd_go;

    function automatic logic [IW-1:0] ring(input logic [IW-1:0] a, input logic [CW-1:0] b);
        logic [IW:0] s;
        s = (IW+1)'(a) + (IW+1)'(b);
        if (s >= (IW+1)'(MAX_THREADS))
        begin
            s = s - (IW+1)'(MAX_THREADS);
        end
        return s[IW-1:0];
    endfunction

    function automatic logic [QW-1:0] sat_inc(input logic [QW-1:0] v);
        return (v == rrts_pkg::CNT_MAX) ? v : v + QW'(1);
    endfunction

    rrts_ram #(.WIDTH(IW), .DEPTH(MAX_THREADS)) u_fifo_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    rrts_ram #(.WIDTH(QW), .DEPTH(MAX_THREADS)) u_quanta_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    assign tid_idx   = IW'(req.tid);
    assign tid_ok    = (32'(req.tid) < MAX_THREADS) && live_reg[tid_idx];
    assign q_val     = (qra_reg == '0 && !q0_wr_reg) ? QW'(1) : q_rdata;
    assign rd_go     = rd_reg < cnt_reg;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_RESP);

    always_comb
    begin
        rsp.status         = status_reg;
        rsp.value          = value_reg;
        rsp.running_thread = 6'(cur_reg);
        rsp.total_quanta   = total_reg;
    end

    always_comb
    begin
        state_next  = state_reg;
        live_next   = live_reg;
        head_next   = head_reg;
        cnt_next    = cnt_reg;
        cur_next    = cur_reg;
        total_next  = total_reg;
        q0_wr_next  = q0_wr_reg;
        idx_next    = idx_reg;
        tid_next    = tid_reg;
        nxt_next    = nxt_reg;
        rd_next     = rd_reg;
        w_next      = w_reg;
        pend_next   = 1'b0;
        qra_next    = qra_reg;
        status_next = status_reg;
        value_next  = value_reg;
        f_we        = 1'b0;
        f_waddr     = ring(head_reg, cnt_reg);
        f_wdata     = cur_reg;
        f_raddr     = head_reg;
        q_we        = 1'b0;
        q_waddr     = nxt_reg;
        q_wdata     = sat_inc(q_val);
        q_raddr     = nxt_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                q_raddr = tid_idx;
                if (req_valid)
                begin
                    status_next = rrts_pkg::ST_OK;
                    value_next  = '0;
                    tid_next    = tid_idx;
                    qra_next    = tid_idx;
                    state_next  = S_RESP;
                    unique case (req.cmd)
                        rrts_pkg::CMD_SPAWN:
                        begin
                            if (req.entry_addr == '0)
                            begin
                                status_next = rrts_pkg::ST_INVALID;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_SEARCH;
                            end
                        end
                        rrts_pkg::CMD_TERM:
                        begin
                            if (req.tid == '0)
                            begin
                                live_next   = MAX_THREADS'(1);
                                head_next   = '0;
                                cnt_next    = '0;
                                cur_next    = '0;
                                total_next  = QW'(1);
                                q0_wr_next  = 1'b0;
                                status_next = rrts_pkg::ST_SHUTDOWN;
                            end
                            else if (!tid_ok)
                            begin
                                status_next = rrts_pkg::ST_NOT_FOUND;
                            end
                            else
                            begin
                                rd_next    = '0;
                                w_next     = '0;
                                state_next = S_COMPACT;
                            end
                        end
                        rrts_pkg::CMD_YIELD:
                        begin
                            if (req.sleep_count != '0)
                            begin
                                status_next = rrts_pkg::ST_SLEEP;
                            end
                            else
                            begin
                                state_next = S_PUSH;
                            end
                        end
                        rrts_pkg::CMD_QUERY:
                        begin
                            if (!tid_ok)
                            begin
                                status_next = rrts_pkg::ST_NOT_FOUND;
                            end
                            else
                            begin
                                state_next = S_QRY_DATA;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                if (!live_reg[idx_reg])
                begin
                    live_next[idx_reg] = 1'b1;
                    q_we       = 1'b1;
                    q_waddr    = idx_reg;
                    q_wdata    = '0;
                    f_wdata    = idx_reg;
                    if (cnt_reg < CW'(MAX_THREADS))
                    begin
                        f_we     = 1'b1;
                        cnt_next = cnt_reg + CW'(1);
                    end
                    value_next = QW'(idx_reg);
                    state_next = S_RESP;
                end
                else if (idx_reg == IW'(MAX_THREADS - 1))
                begin
                    status_next = rrts_pkg::ST_NO_ID;
                    state_next  = S_RESP;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_COMPACT:
            begin
                f_raddr = ring(head_reg, rd_reg);
                f_waddr = ring(head_reg, w_reg);
                f_wdata = f_rdata;
                if (rd_go)
                begin
                    rd_next   = rd_reg + CW'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg && f_rdata != tid_reg)
                begin
                    f_we   = 1'b1;
                    w_next = w_reg + CW'(1);
                end
                if (!rd_go && !pend_reg)
                begin
                    cnt_next           = w_reg;
                    live_next[tid_reg] = 1'b0;
                    if (tid_reg == cur_reg)
                    begin
                        if (w_reg != '0)
                        begin
                            state_next = S_HEAD_RD;
                        end
                        else
                        begin
                            nxt_next   = '0;
                            state_next = S_Q_RD;
                        end
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_PUSH:
            begin
                if (cnt_reg < CW'(MAX_THREADS))
                begin
                    f_we     = 1'b1;
                    cnt_next = cnt_reg + CW'(1);
                end
                state_next = S_HEAD_RD;
            end
            S_HEAD_RD:
            begin
                state_next = S_HEAD_DATA;
            end
            S_HEAD_DATA:
            begin
                nxt_next   = f_rdata;
                head_next  = (head_reg == IW'(MAX_THREADS - 1)) ? '0 : head_reg + IW'(1);
                cnt_next   = cnt_reg - CW'(1);
                state_next = S_Q_RD;
            end
            S_Q_RD:
            begin
                qra_next   = nxt_reg;
                state_next = S_Q_DATA;
            end
            S_Q_DATA:
            begin
                q_we       = 1'b1;
                cur_next   = nxt_reg;
                total_next = sat_inc(total_reg);
                if (nxt_reg == '0)
                begin
                    q0_wr_next = 1'b1;
                end
                state_next = S_RESP;
            end
            S_QRY_DATA:
            begin
                value_next = q_val;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (rsp_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            live_reg  <= MAX_THREADS'(1);
            head_reg  <= '0;
            cnt_reg   <= '0;
            cur_reg   <= '0;
            total_reg <= QW'(1);
            q0_wr_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            live_reg  <= live_next;
            head_reg  <= head_next;
            cnt_reg   <= cnt_next;
            cur_reg   <= cur_next;
            total_reg <= total_next;
            q0_wr_reg <= q0_wr_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        tid_reg    <= tid_next;
        nxt_reg    <= nxt_next;
        rd_reg     <= rd_next;
        w_reg      <= w_next;
        qra_reg    <= qra_next;
        status_reg <= status_next;
        value_reg  <= value_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_THREADS))
        else $error("ready count above depth");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(head_reg) < MAX_THREADS)
        else $error("head pointer out of range");

    a_zero_live: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg[0])
        else $error("thread zero not live");

    a_cur_live: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> live_reg[cur_reg])
        else $error("running thread not live");

    a_pend_compact: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(state_reg) == S_COMPACT)
        else $error("stray read pending");

endmodule

// ===== sim/round_robin_thread_scheduler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_tb
// Drives scheduler requests through the valid/ready channel, predicts each
// response from a local model of the thread table and ready FIFO (or the
// directed table), checks it field by field under varying sender and receiver stalls.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler_tb;

    localparam int NTHR = 64;
    localparam int QW   = rrts_pkg::CNT_W;

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_ready;
    rrts_pkg::req_t req;
    logic           rsp_valid;
    logic           rsp_ready;
    rrts_pkg::rsp_t rsp;

    round_robin_thread_scheduler dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    // scheduler state mirror
    logic [5:0]    run_q[$];
    logic          live[NTHR];
    logic [QW-1:0] quanta[NTHR];
    logic [5:0]    cur_thr;
    logic [QW-1:0] total_q;

    rrts_pkg::rsp_t rsp_pending[$];
    int             errors;
    int             send_idle_pct;
    int             recv_idle_pct;
    bit             hold_off;

    typedef struct {
        rrts_pkg::req_t r;
        bit             has_rsp;
        rrts_pkg::rsp_t rs;
    } row_t;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("round_robin_thread_scheduler_tb failed");
        $finish;
    end

    function automatic logic [QW-1:0] sat_inc(logic [QW-1:0] v);
        return (v == rrts_pkg::CNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic void sched_reset();
        run_q.delete();
        for (int i = 0; i < NTHR; i++)
        begin
            live[i] = 1'b0;
            quanta[i] = '0;
        end
        live[0] = 1'b1;
        quanta[0] = QW'(1);
        cur_thr = '0;
        total_q = QW'(1);
    endfunction

    function automatic void start_head();
        logic [5:0] nxt;
        nxt = '0;
        if (run_q.size() > 0)
        begin
            nxt = run_q[0];
            run_q.delete(0);
        end
        cur_thr = nxt;
        quanta[nxt] = sat_inc(quanta[nxt]);
        total_q = sat_inc(total_q);
    endfunction

    function automatic rrts_pkg::rsp_t sched_predict(rrts_pkg::req_t r);
        rrts_pkg::rsp_t o;
        int             id;
        o.status = rrts_pkg::ST_OK;
        o.value = '0;
        case (r.cmd)
            rrts_pkg::CMD_SPAWN:
            begin
                if (r.entry_addr == 0)
                    o.status = rrts_pkg::ST_INVALID;
                else
                begin
                    id = -1;
                    for (int i = 0; i < NTHR; i++)
                        if (!live[i] && id < 0)
                            id = i;
                    if (id < 0)
                        o.status = rrts_pkg::ST_NO_ID;
                    else
                    begin
                        live[id] = 1'b1;
                        quanta[id] = '0;
                        run_q.insert(run_q.size(), id[5:0]);
                        o.value = QW'(id);
                    end
                end
            end
            rrts_pkg::CMD_TERM:
            begin
                if (r.tid == 0)
                begin
                    sched_reset();
                    o.status = rrts_pkg::ST_SHUTDOWN;
                end
                else if (!live[r.tid])
                    o.status = rrts_pkg::ST_NOT_FOUND;
                else
                begin
                    for (int i = run_q.size() - 1; i >= 0; i--)
                        if (run_q[i] == r.tid)
                            run_q.delete(i);
                    live[r.tid] = 1'b0;
                    quanta[r.tid] = '0;
                    if (r.tid == cur_thr)
                        start_head();
                end
            end
            rrts_pkg::CMD_YIELD:
            begin
                if (r.sleep_count != 0)
                    o.status = rrts_pkg::ST_SLEEP;
                else
                begin
                    run_q.insert(run_q.size(), cur_thr);
                    start_head();
                end
            end
            default:
            begin
                if (!live[r.tid])
                    o.status = rrts_pkg::ST_NOT_FOUND;
                else
                    o.value = quanta[r.tid];
            end
        endcase
        o.running_thread = cur_thr;
        o.total_quanta = total_q;
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint exp);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, exp);
        errors++;
    endtask

    function automatic rrts_pkg::req_t mk_req(rrts_pkg::cmd_t c, int t, logic [31:0] a,
                                              logic [7:0] s);
        rrts_pkg::req_t r;
        r.cmd = c;
        r.tid = t[5:0];
        r.entry_addr = a;
        r.sleep_count = s;
        return r;
    endfunction

    // send one request and queue its expected response
    task automatic send_req(rrts_pkg::req_t r, bit has_rsp = 0, rrts_pkg::rsp_t fixed = '0);
        rrts_pkg::rsp_t p;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req <= r;
        req_valid <= 1'b1;
        p = sched_predict(r);
        if (has_rsp)
            p = fixed;
        rsp_pending.insert(rsp_pending.size(), p);
        do @(posedge clk); while (!req_ready);
        @(negedge clk);
    endtask

    // response checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (rsp_pending.size() == 0)
            begin
                report_mismatch("unexpected response", 1, 0);
            end
            else
            begin
                rrts_pkg::rsp_t e;
                e = rsp_pending[0];
                rsp_pending.delete(0);
                if (rsp.status !== e.status)
                    report_mismatch("status", rsp.status, e.status);
                if (rsp.value !== e.value)
                    report_mismatch("value", rsp.value, e.value);
                if (rsp.running_thread !== e.running_thread)
                    report_mismatch("running_thread", rsp.running_thread, e.running_thread);
                if (rsp.total_quanta !== e.total_quanta)
                    report_mismatch("total_quanta", rsp.total_quanta, e.total_quanta);
            end
        end
    end

    // receiver stalls
    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                rsp_ready <= 1'b0;
                repeat (600) @(negedge clk);
                hold_off = 0;
            end
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic rrts_pkg::req_t rand_req();
        rrts_pkg::req_t r;
        int             k;
        k = $urandom_range(99);
        r.tid = 6'($urandom_range(63));
        r.entry_addr = $urandom;
        if ($urandom_range(15) == 0)
            r.entry_addr = 0;
        r.sleep_count = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'd0;
        if (k < 35)
            r.cmd = rrts_pkg::CMD_SPAWN;
        else if (k < 55)
            r.cmd = rrts_pkg::CMD_YIELD;
        else if (k < 80)
            r.cmd = rrts_pkg::CMD_QUERY;
        else
        begin
            r.cmd = rrts_pkg::CMD_TERM;
            if (r.tid == 0 && $urandom_range(9) != 0)
                r.tid = 6'(1 + $urandom_range(62));
        end
        if (r.cmd != rrts_pkg::CMD_SPAWN && $urandom_range(2) != 0 && run_q.size() > 0)
            r.tid = run_q[$urandom_range(run_q.size() - 1)];
        return r;
    endfunction

    initial
    begin
        row_t rows[$];
        row_t rw;
        int   wait_cnt;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        errors = 0;
        send_idle_pct = 14;
        recv_idle_pct = 72;
        hold_off = 0;
        sched_reset();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        rw.has_rsp = 1; rw.r = mk_req(rrts_pkg::CMD_QUERY, 0, 0, 0);
        rw.rs = '{rrts_pkg::ST_OK, 1, 0, 1}; rows.insert(rows.size(), rw);
        rw.r = mk_req(rrts_pkg::CMD_QUERY, 63, 0, 0);
        rw.rs = '{rrts_pkg::ST_NOT_FOUND, 0, 0, 1}; rows.insert(rows.size(), rw);
        rw.r = mk_req(rrts_pkg::CMD_SPAWN, 0, 0, 0);
        rw.rs = '{rrts_pkg::ST_INVALID, 0, 0, 1}; rows.insert(rows.size(), rw);
        rw.r = mk_req(rrts_pkg::CMD_YIELD, 0, 0, 8'hFF);
        rw.rs = '{rrts_pkg::ST_SLEEP, 0, 0, 1}; rows.insert(rows.size(), rw);
        rw.r = mk_req(rrts_pkg::CMD_YIELD, 0, 0, 0);
        rw.rs = '{rrts_pkg::ST_OK, 0, 0, 2}; rows.insert(rows.size(), rw);
        rw.r = mk_req(rrts_pkg::CMD_TERM, 5, 0, 0);
        rw.rs = '{rrts_pkg::ST_NOT_FOUND, 0, 0, 2}; rows.insert(rows.size(), rw);
        rw.r = mk_req(rrts_pkg::CMD_SPAWN, 0, 32'hFFFF_FFFF, 0);
        rw.rs = '{rrts_pkg::ST_OK, 1, 0, 2}; rows.insert(rows.size(), rw);
        rw.has_rsp = 0;
        rw.r = mk_req(rrts_pkg::CMD_SPAWN, 0, 32'h1, 0); rows.insert(rows.size(), rw);
        rw.r = mk_req(rrts_pkg::CMD_YIELD, 0, 0, 0); rows.insert(rows.size(), rw);
        rw.r = mk_req(rrts_pkg::CMD_QUERY, 1, 0, 0); rows.insert(rows.size(), rw);
        rw.r = mk_req(rrts_pkg::CMD_TERM, 1, 0, 0); rows.insert(rows.size(), rw);
        rw.r = mk_req(rrts_pkg::CMD_TERM, 2, 0, 0); rows.insert(rows.size(), rw);
        rw.r = mk_req(rrts_pkg::CMD_SPAWN, 42, 32'h8000_0000, 0); rows.insert(rows.size(), rw);
        rw.r = mk_req(rrts_pkg::CMD_YIELD, 0, 0, 1); rows.insert(rows.size(), rw);
        rw.has_rsp = 1; rw.r = mk_req(rrts_pkg::CMD_TERM, 0, 0, 0);
        rw.rs = '{rrts_pkg::ST_SHUTDOWN, 0, 0, 1}; rows.insert(rows.size(), rw);
        foreach (rows[i])
            send_req(rows[i].r, rows[i].has_rsp, rows[i].rs);

        // fill the table: 63 spawns then one refused
        for (int i = 0; i < 64; i++)
            send_req(mk_req(rrts_pkg::CMD_SPAWN, 0, 32'h100 + i, 0));
        // stall the receiver while requests keep coming
        hold_off = 1;
        for (int i = 0; i < 20; i++)
            send_req(mk_req(rrts_pkg::CMD_YIELD, 0, 0, 0));
        send_req(mk_req(rrts_pkg::CMD_TERM, 63, 0, 0));
        send_req(mk_req(rrts_pkg::CMD_TERM, 0, 0, 0));

        for (int ph = 0; ph < 3; ph++)
        begin
            if (ph == 1)
            begin
                send_idle_pct = 72;
                recv_idle_pct = 14;
            end
            else if (ph == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int i = 0; i < 240; i++)
                send_req(rand_req());
        end
        req_valid <= 1'b0;

        wait_cnt = 0;
        while (rsp_pending.size() > 0 && wait_cnt < 200000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (100) @(posedge clk);
        if (errors == 0 && rsp_pending.size() == 0)
            $display("round_robin_thread_scheduler_tb passed");
        else
            $display("round_robin_thread_scheduler_tb failed");
        $finish;
    end

endmodule
